[src/mux_chain_channel_select_spi_unit_defines.svh]
// Assertion macros for the mux chain channel select SPI unit.
// Included by files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef MUX_CHAIN_CHANNEL_SELECT_SPI_UNIT_DEFINES_SVH
`define MUX_CHAIN_CHANNEL_SELECT_SPI_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MCSS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MCSS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCSS_ASSERT_CLK(label, prop, msg)
`define MCSS_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[src/mcss_pkg.sv]
// Shared types and constants for the mux chain channel select SPI unit.
// No dependencies; used by the front end, the queue, the shadow engine and the top level.
package mcss_pkg;

    localparam int CHAIN_W = 5;
    localparam int DEV_W   = 4;

    localparam logic [2:0] REQ_SEL_A  = 3'd0;
    localparam logic [2:0] REQ_SEL_B  = 3'd1;
    localparam logic [2:0] REQ_NEXT_A = 3'd2;
    localparam logic [2:0] REQ_NEXT_B = 3'd3;
    localparam logic [2:0] REQ_ALL_A  = 3'd4;
    localparam logic [2:0] REQ_ALL_B  = 3'd5;
    localparam logic [2:0] REQ_CLEAR  = 3'd6;

    localparam logic [1:0] OP_ROW    = 2'd0;
    localparam logic [1:0] OP_ALL    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_REJECT = 2'd3;

    localparam logic [31:0] ROW_ALL_A = 32'h0000_FFFF;
    localparam logic [31:0] ROW_ALL_B = 32'hFFFF_0000;

    typedef struct packed {
        logic [1:0]       op;
        logic [DEV_W-1:0] row;
        logic [31:0]      data;
    } desc_t;

endpackage

[src/mcss_channels.sv]
// Handshake channels of the mux chain channel select SPI unit.
// Depends on nothing; carries valid, ready and the payload of each channel.
interface mcss_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] channel;

    modport source (output valid, output req_type, output channel, input ready);
    modport sink (input valid, input req_type, input channel, output ready);
endinterface

interface mcss_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] spi_byte;
    logic       last;

    modport source (output valid, output ok, output spi_byte, output last, input ready);
    modport sink (input valid, input ok, input spi_byte, input last, output ready);
endinterface

[src/mcss_front.sv]
// Command front end: accepts requests, tracks active channels, builds descriptors.
// Depends on mcss_pkg and the request channel interface.
module mcss_front (
    input  logic                        clk,
    input  logic                        rst_n,
    mcss_req_if.sink                    req,
    input  logic [mcss_pkg::CHAIN_W-1:0] n_eff,
    input  logic                        q_ready,
    output logic                        push,
    output mcss_pkg::desc_t             push_desc
);

    logic [7:0]  active_a_reg;
    logic [7:0]  active_b_reg;
    logic [7:0]  nxt_a;
    logic [7:0]  nxt_b;
    logic [7:0]  ch_sel;
    logic        is_sel;
    logic        is_next;
    logic        bus_b;
    logic        in_range;
    logic [mcss_pkg::CHAIN_W-1:0] dev;
    logic [15:0] word;
    logic        accept;

    assign req.ready = q_ready;
    assign accept    = req.valid && q_ready;

    always_comb
    begin
        nxt_a = active_a_reg + 8'd1;
        if ({1'b0, nxt_a[7:4]} >= n_eff)
        begin
            nxt_a = 8'd0;
        end
        nxt_b = active_b_reg + 8'd1;
        if ({1'b0, nxt_b[7:4]} >= n_eff)
        begin
            nxt_b = 8'd0;
        end
    end

    assign is_sel  = (req.req_type == mcss_pkg::REQ_SEL_A) ||
                     (req.req_type == mcss_pkg::REQ_SEL_B);
    assign is_next = (req.req_type == mcss_pkg::REQ_NEXT_A) ||
                     (req.req_type == mcss_pkg::REQ_NEXT_B);
    assign bus_b   = (req.req_type == mcss_pkg::REQ_SEL_B) ||
                     (req.req_type == mcss_pkg::REQ_NEXT_B);

    always_comb
    begin
        if (is_sel)
        begin
            ch_sel = req.channel;
        end
        else if (bus_b)
        begin
            ch_sel = nxt_b;
        end
        else
        begin
            ch_sel = nxt_a;
        end
    end

    assign in_range = {1'b0, ch_sel[7:4]} < n_eff;
    assign dev      = n_eff - 5'd1 - {1'b0, ch_sel[7:4]};
    assign word     = 16'h0001 << ch_sel[3:0];

    always_comb
    begin
        push_desc.op   = mcss_pkg::OP_ROW;
        push_desc.row  = dev[mcss_pkg::DEV_W-1:0];
        push_desc.data = bus_b ? {word, ~word} : {~word, word};
        push           = accept;
        unique case (req.req_type)
            mcss_pkg::REQ_SEL_A, mcss_pkg::REQ_SEL_B,
            mcss_pkg::REQ_NEXT_A, mcss_pkg::REQ_NEXT_B:
            begin
                if (!in_range)
                begin
                    push_desc.op = mcss_pkg::OP_REJECT;
                end
            end
            mcss_pkg::REQ_ALL_A:
            begin
                push_desc.op   = mcss_pkg::OP_ALL;
                push_desc.data = mcss_pkg::ROW_ALL_A;
            end
            mcss_pkg::REQ_ALL_B:
            begin
                push_desc.op   = mcss_pkg::OP_ALL;
                push_desc.data = mcss_pkg::ROW_ALL_B;
            end
            mcss_pkg::REQ_CLEAR:
            begin
                push_desc.op = mcss_pkg::OP_CLEAR;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_a_reg <= 8'd0;
            active_b_reg <= 8'd0;
        end
        else if (accept && (is_sel || is_next) && in_range)
        begin
            if (bus_b)
            begin
                active_b_reg <= ch_sel;
            end
            else
            begin
                active_a_reg <= ch_sel;
            end
        end
    end

endmodule

[src/mcss_queue.sv]
// Two-entry descriptor queue between the command front end and the shadow engine.
// Depends on mcss_pkg for the descriptor type.
module mcss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mcss_pkg::desc_t push_desc,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output mcss_pkg::desc_t q_desc
);

    mcss_pkg::desc_t entries_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign q_ready = count_reg != 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_desc  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[src/mcss_back.sv]
// Shadow engine: applies descriptors to the row memory and streams the shadow bytes.
// Depends on mcss_pkg and the response channel interface.
module mcss_back #(
    parameter int MAX_CHAIN = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mcss_pkg::CHAIN_W-1:0] n_eff,
    input  logic                         q_valid,
    input  mcss_pkg::desc_t              q_desc,
    output logic                         pop,
    mcss_rsp_if.source                   rsp
);

    localparam int ROW_W = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    logic [1:0]           state_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [1:0]           byte_reg;
    mcss_pkg::desc_t      cmd_reg;
    logic [31:0]          mem [MAX_CHAIN];
    logic [MAX_CHAIN-1:0] valid_reg;
    logic [31:0]          rd_data_reg;
    logic                 rd_valid_reg;
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 emit;
    logic                 row_last;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [31:0]          src_row;
    logic [7:0]           src_byte;

    assign out_free = !out_valid_reg || rsp.ready;
    assign emit     = out_free &&
                      (((state_reg == ST_EXEC) && (cmd_reg.op == mcss_pkg::OP_REJECT)) ||
                       (state_reg == ST_SEND));
    assign row_last = ({{(mcss_pkg::CHAIN_W-ROW_W){1'b0}}, row_reg} == (n_eff - 5'd1));
    assign pop      = (state_reg == ST_IDLE) && q_valid;

    assign rsp.valid    = out_valid_reg;
    assign rsp.ok       = out_ok_reg;
    assign rsp.spi_byte = out_byte_reg;
    assign rsp.last     = out_last_reg;

    assign wr_en   = (state_reg == ST_EXEC) &&
                     ((cmd_reg.op == mcss_pkg::OP_ROW) || (cmd_reg.op == mcss_pkg::OP_ALL));
    assign wr_addr = (cmd_reg.op == mcss_pkg::OP_ROW) ? cmd_reg.row[ROW_W-1:0] : row_reg;

    assign src_row = rd_valid_reg ? rd_data_reg : 32'd0;

    always_comb
    begin
        unique case (byte_reg)
            2'd0: src_byte = src_row[31:24];
            2'd1: src_byte = src_row[23:16];
            2'd2: src_byte = src_row[15:8];
            default: src_byte = src_row[7:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd_reg.data;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg  <= mem[row_reg];
            rd_valid_reg <= valid_reg[row_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            byte_reg      <= 2'd0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_byte_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        row_reg   <= '0;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    unique case (cmd_reg.op)
                        mcss_pkg::OP_ROW:
                        begin
                            valid_reg[cmd_reg.row[ROW_W-1:0]] <= 1'b1;
                            row_reg                           <= '0;
                            state_reg                         <= ST_READ;
                        end
                        mcss_pkg::OP_ALL:
                        begin
                            valid_reg[row_reg] <= 1'b1;
                            if (row_last)
                            begin
                                row_reg   <= '0;
                                state_reg <= ST_READ;
                            end
                            else
                            begin
                                row_reg <= row_reg + 1'b1;
                            end
                        end
                        mcss_pkg::OP_CLEAR:
                        begin
                            valid_reg <= '0;
                            row_reg   <= '0;
                            state_reg <= ST_READ;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                out_ok_reg    <= 1'b0;
                                out_byte_reg  <= 8'd0;
                                out_last_reg  <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                        end
                    endcase
                end
                ST_READ:
                begin
                    byte_reg  <= 2'd0;
                    state_reg <= ST_SEND;
                end
                default:
                begin
                    if (out_free)
                    begin
                        out_ok_reg    <= 1'b1;
                        out_byte_reg  <= src_byte;
                        out_last_reg  <= (byte_reg == 2'd3) && row_last;
                        byte_reg      <= byte_reg + 2'd1;
                        if (byte_reg == 2'd3)
                        begin
                            if (row_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                row_reg   <= row_reg + 1'b1;
                                state_reg <= ST_READ;
                            end
                        end
                    end
                end
            endcase
        end
    end

endmodule

[src/mux_chain_channel_select_spi_unit.sv]
// A request enters the two-entry queue, is popped into the command register in the idle
// state and is applied in the execute state, which steps through every device row for
// all-A or all-B. Each device's row is then read in the read state and its four bytes are
// sent through the output register; a rejection sends a single byte from the execute state.
// The front end accepts up to two further commands into the queue meanwhile.
// Reset: the shadow reads as zero, active channels are zero, the chain length is one.
`include "mux_chain_channel_select_spi_unit_defines.svh"

module mux_chain_channel_select_spi_unit #(
    parameter int MAX_CHAIN = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mcss_req_if.sink                     req,
    mcss_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [mcss_pkg::CHAIN_W-1:0] cfg_wdata
);

    logic [mcss_pkg::CHAIN_W-1:0] chain_reg;
    logic [mcss_pkg::CHAIN_W-1:0] n_eff;
    logic                         push;
    logic                         q_ready;
    logic                         q_valid;
    logic                         pop;
    mcss_pkg::desc_t              push_desc;
    mcss_pkg::desc_t              q_desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            chain_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (chain_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (chain_reg > 5'(MAX_CHAIN))
        begin
            n_eff = 5'(MAX_CHAIN);
        end
        else
        begin
            n_eff = chain_reg;
        end
    end

    mcss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .n_eff     (n_eff),
        .q_ready   (q_ready),
        .push      (push),
        .push_desc (push_desc)
    );

    mcss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    mcss_back #(
        .MAX_CHAIN (MAX_CHAIN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .n_eff   (n_eff),
        .q_valid (q_valid),
        .q_desc  (q_desc),
        .pop     (pop),
        .rsp     (rsp)
    );

    `MCSS_ASSERT_NEVER(a_push_full, push && !q_ready, "descriptor pushed into a full queue")
    `MCSS_ASSERT_NEVER(a_pop_empty, pop && !q_valid, "descriptor popped from an empty queue")
    `MCSS_ASSERT_CLK(a_reject_form, rsp.valid && !rsp.ok |-> rsp.last && (rsp.spi_byte == 8'd0), "bad rejection")

endmodule
